[rtl/ipool_pkg.sv]
// ipool_pkg: shared types and constants of the int8 2-D pooling block
// no dependencies; imported by every module of the block
package ipool_pkg;

  // default sizes of the top-level parameters
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_WINDOW = 3;

  // largest window the job words are sized for
  localparam int KMAX  = 3;
  localparam int NWIN  = KMAX * KMAX;
  // signed width of geometry arithmetic (rows, columns, window origins)
  localparam int GEO_W = 14;
  // depth of the job queue and of the result queue
  localparam int QUEUE_DEPTH = 4;
  // magnitude width of a window sum (9 * 128 fits)
  localparam int DIV_W = 11;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_POOL_MODE    = 3'd0,
    REG_WIN_SIDE     = 3'd1,
    REG_STEP_SIZE    = 3'd2,
    REG_PAD_AMOUNT   = 3'd3,
    REG_PLANE_HEIGHT = 3'd4,
    REG_PLANE_WIDTH  = 3'd5
  } cfg_reg_e;

  // configuration register file
  typedef struct packed {
    logic       pool_mode;
    logic [1:0] win_side;
    logic [1:0] step_size;
    logic       pad_amount;
    logic [8:0] plane_height;
    logic [8:0] plane_width;
  } cfg_t;

  // one window handed from front to back: pixels, in-bounds mask, position
  typedef struct packed {
    logic [NWIN-1:0][7:0] vals;
    logic [NWIN-1:0]      mask;
    logic [8:0]           out_row;
    logic [8:0]           out_col;
    logic                 last;
  } job_t;

  // one finished result word
  typedef struct packed {
    logic [7:0] pooled;
    logic [8:0] out_row;
    logic [8:0] out_col;
    logic       plane_done;
  } result_t;

endpackage

[rtl/ipool_fifo.sv]
// ipool_fifo: small register queue carrying words of any packed type
// depends on ipool_pkg (default depth)
module ipool_fifo
  import ipool_pkg::*;
#(
  parameter int  DEPTH = QUEUE_DEPTH,
  parameter type T     = logic [7:0]
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // the fill count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count above depth");

  // a push alone grows the count by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");

  // a pop alone shrinks the count by one
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not shrink on pop");

endmodule

[rtl/ipool_front.sv]
// ipool_front: pixel intake, line store, window columns and window finder
// depends on ipool_pkg; feeds one job per completed window into the job queue
module ipool_front
  import ipool_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       restart_i,
  input  logic       push_i,
  input  logic [7:0] pixel_i,
  output logic       full_o,
  output job_t       job_o,
  output logic       job_push_o,
  input  logic       job_full_i
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WIN_IW = $clog2(MAX_WINDOW);
  localparam int SLOT_W = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW - 1) : 1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_LOAD,
    F_EMIT
  } front_state_e;

  typedef logic signed [GEO_W-1:0] geo_t;

  front_state_e                  state_q;
  geo_t                          row_q, col_q, oh_q, ow_q, ow0_q;
  logic [SLOT_W-1:0]             slot_q;
  logic [7:0]                    px_q;
  logic [MAX_WINDOW-2:0][7:0]    rdata_q;
  logic [MAX_WINDOW-2:0][7:0]    line_mem [MAX_WIDTH];
  logic [MAX_WINDOW-2:0][7:0]    wrow;
  logic [MAX_WINDOW-1:0][7:0]    win_q [MAX_WINDOW];
  logic [MAX_WINDOW-1:0][7:0]    cur;
  logic [AW-1:0]                 col_addr;

  geo_t k, s, p, h, w, out_h, out_w;
  geo_t t_row, t_col, oh0, ow0;
  geo_t ohs, ows, rl, cl, rmin, cmin;
  logic row_ok, col_ok, accept;

  assign full_o   = (state_q != F_IDLE);
  assign accept   = push_i && !full_o;
  assign col_addr = col_q[AW-1:0];

  // clamped geometry from the register file
  always_comb begin
    k = (cfg_i.win_side < 2'd2) ? geo_t'(2)
      : ((GEO_W'(cfg_i.win_side) > GEO_W'(MAX_WINDOW)) ? geo_t'(MAX_WINDOW)
         : geo_t'(cfg_i.win_side));
    s = (cfg_i.step_size == 2'd0) ? geo_t'(1)
      : ((cfg_i.step_size == 2'd3) ? geo_t'(2) : geo_t'(cfg_i.step_size));
    p = geo_t'(cfg_i.pad_amount);
    h = (cfg_i.plane_height < 9'd3) ? geo_t'(3)
      : ((GEO_W'(cfg_i.plane_height) > GEO_W'(MAX_HEIGHT)) ? geo_t'(MAX_HEIGHT)
         : geo_t'(cfg_i.plane_height));
    w = (cfg_i.plane_width < 9'd3) ? geo_t'(3)
      : ((GEO_W'(cfg_i.plane_width) > GEO_W'(MAX_WIDTH)) ? geo_t'(MAX_WIDTH)
         : geo_t'(cfg_i.plane_width));
    out_h = geo_t'(((s == 2) ? ((h + 2 * p - k) >>> 1) : (h + 2 * p - k)) + 1);
    out_w = geo_t'(((s == 2) ? ((w + 2 * p - k) >>> 1) : (w + 2 * p - k)) + 1);
  end

  // first output row and column that this pixel can complete
  always_comb begin
    t_row = geo_t'(row_q + p + 1 - k);
    t_col = geo_t'(col_q + p + 1 - k);
    oh0   = (t_row <= 0) ? geo_t'(0) : ((s == 2) ? geo_t'((t_row + 1) >>> 1) : t_row);
    ow0   = (t_col <= 0) ? geo_t'(0) : ((s == 2) ? geo_t'((t_col + 1) >>> 1) : t_col);
  end

  // current column: new pixel on top, older rows from the line store
  always_comb begin
    logic [SLOT_W:0] sl;
    cur    = '0;
    cur[0] = px_q;
    for (int d = 1; d < MAX_WINDOW; d++) begin
      sl = {1'b0, slot_q} + (SLOT_W + 1)'(MAX_WINDOW - 1 - d);
      if (sl >= (SLOT_W + 1)'(MAX_WINDOW - 1)) begin
        sl = sl - (SLOT_W + 1)'(MAX_WINDOW - 1);
      end
      cur[d] = rdata_q[sl[SLOT_W-1:0]];
    end
    wrow         = rdata_q;
    wrow[slot_q] = px_q;
  end

  // window candidate checks for the current output position
  always_comb begin
    ohs    = (s == 2) ? (oh_q <<< 1) : oh_q;
    ows    = (s == 2) ? (ow_q <<< 1) : ow_q;
    rl     = geo_t'(ohs - p + k - 1);
    cl     = geo_t'(ows - p + k - 1);
    rmin   = (rl < h - 1) ? rl : geo_t'(h - 1);
    cmin   = (cl < w - 1) ? cl : geo_t'(w - 1);
    row_ok = (oh_q < out_h) && (rmin == row_q);
    col_ok = (ow_q < out_w) && (cmin == col_q);
  end

  // gather the window pixels; entries outside the plane are masked off
  always_comb begin
    geo_t ir, ic, dv, jv;
    logic use_it;
    job_o = '0;
    for (int kh = 0; kh < KMAX; kh++) begin
      for (int kw = 0; kw < KMAX; kw++) begin
        ir = ohs - p + geo_t'(kh);
        ic = ows - p + geo_t'(kw);
        dv = row_q - ir;
        jv = col_q - ic;
        use_it = (geo_t'(kh) < k) && (geo_t'(kw) < k)
              && (ir >= 0) && (ir < h) && (ic >= 0) && (ic < w)
              && (dv >= 0) && (dv < geo_t'(MAX_WINDOW))
              && (jv >= 0) && (jv < geo_t'(MAX_WINDOW));
        job_o.mask[kh*KMAX+kw] = use_it;
        if (use_it) begin
          job_o.vals[kh*KMAX+kw] = win_q[jv[WIN_IW-1:0]][dv[WIN_IW-1:0]];
        end
      end
    end
    job_o.out_row = oh_q[8:0];
    job_o.out_col = ow_q[8:0];
    job_o.last    = (oh_q == out_h - 1) && (ow_q == out_w - 1);
  end

  assign job_push_o = (state_q == F_EMIT) && row_ok && col_ok && !job_full_i;

  // sequencer: read line, shift window, emit completed windows, advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      slot_q  <= '0;
      oh_q    <= '0;
      ow_q    <= '0;
      ow0_q   <= '0;
    end else if (restart_i) begin
      state_q <= F_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      slot_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            state_q <= F_LOAD;
          end
        end
        F_LOAD: begin
          oh_q    <= oh0;
          ow_q    <= ow0;
          ow0_q   <= ow0;
          state_q <= F_EMIT;
        end
        F_EMIT: begin
          if (!row_ok) begin
            state_q <= F_IDLE;
            if (col_q + 1 >= w) begin
              col_q <= '0;
              if (row_q + 1 >= h) begin
                row_q  <= '0;
                slot_q <= '0;
              end else begin
                row_q  <= geo_t'(row_q + 1);
                slot_q <= (slot_q == SLOT_W'(MAX_WINDOW - 2)) ? '0 : slot_q + 1'b1;
              end
            end else begin
              col_q <= geo_t'(col_q + 1);
            end
          end else if (col_ok) begin
            if (!job_full_i) begin
              ow_q <= geo_t'(ow_q + 1);
            end
          end else begin
            oh_q <= geo_t'(oh_q + 1);
            ow_q <= ow0_q;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // pixel capture, line store and window columns
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= pixel_i;
      rdata_q <= line_mem[col_addr];
    end
    if (state_q == F_LOAD) begin
      line_mem[col_addr] <= wrow;
      win_q[0] <= cur;
      for (int j = 1; j < MAX_WINDOW; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

endmodule

[rtl/ipool_back.sv]
// ipool_back: window reduction (max or sum and count) and serial divider
// depends on ipool_pkg; takes jobs from the job queue, fills the result queue
module ipool_back
  import ipool_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    pool_mode_i,
  input  job_t    job_i,
  input  logic    job_empty_i,
  output logic    job_pop_o,
  output result_t res_o,
  output logic    res_push_o,
  input  logic    res_full_i
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_e;

  back_state_e          state_q;
  logic [DIV_W-1:0]     quo_q;
  logic [3:0]           rem_q, cnt_q;
  logic [STEP_W-1:0]    step_q;
  logic                 neg_q;
  result_t              res_q;

  logic signed [DIV_W:0] sum;
  logic signed [7:0]     mx;
  logic [3:0]            cnt;
  logic [DIV_W-1:0]      mag;
  logic [4:0]            trial;
  logic                  ge;
  logic [DIV_W-1:0]      quo_neg;

  // reduce the head job: sum, maximum and count of in-bounds pixels
  always_comb begin
    sum = '0;
    mx  = -8'sd128;
    for (int i = 0; i < NWIN; i++) begin
      sum = sum + (DIV_W + 1)'($signed(job_i.vals[i]));
      if (job_i.mask[i] && ($signed(job_i.vals[i]) > mx)) begin
        mx = $signed(job_i.vals[i]);
      end
    end
    cnt = 4'($countones(job_i.mask));
    mag = sum[DIV_W] ? DIV_W'(-sum) : sum[DIV_W-1:0];
  end

  // one restoring division step
  always_comb begin
    trial   = {rem_q, quo_q[DIV_W-1]};
    ge      = (trial >= {1'b0, cnt_q});
    quo_neg = -quo_q;
  end

  assign job_pop_o  = (state_q == B_IDLE) && !job_empty_i;
  assign res_push_o = (state_q == B_OUT) && !res_full_i;
  assign res_o      = res_q;

  // reduction, division and hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            res_q.out_row    <= job_i.out_row;
            res_q.out_col    <= job_i.out_col;
            res_q.plane_done <= job_i.last;
            if (pool_mode_i) begin
              res_q.pooled <= mx;
              state_q      <= B_OUT;
            end else begin
              quo_q   <= mag;
              rem_q   <= '0;
              cnt_q   <= cnt;
              neg_q   <= sum[DIV_W];
              step_q  <= STEP_W'(DIV_W);
              state_q <= B_DIV;
            end
          end
        end
        B_DIV: begin
          if (step_q == '0) begin
            res_q.pooled <= neg_q ? quo_neg[7:0] : quo_q[7:0];
            state_q      <= B_OUT;
          end else begin
            rem_q  <= ge ? 4'(trial - {1'b0, cnt_q}) : trial[3:0];
            quo_q  <= {quo_q[DIV_W-2:0], ge};
            step_q <= step_q - 1'b1;
          end
        end
        B_OUT: begin
          if (!res_full_i) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/int8_pool2d_avg_max.sv]
// int8_pool2d_avg_max: top level of the int8 2-D average / max pooling block
// depends on ipool_pkg, ipool_fifo, ipool_front, ipool_back
//
//   channel   handshake                  word
//   pixel     push / full                pixel_i
//   result    pop / empty                pooled_o, out_row_o, out_col_o, plane_done_o
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// a pixel is loaded by the front end, which then emits each completed window and
// steps through each output row it visits; full is high while the front end is busy.
// an average passes through load, an 11-step serial divider, finish and hand-off
// in the back end; a max goes from load straight to hand-off.
// reset clears the configuration registers, position counters and both queues;
// line store and window columns hold no reset; stale contents never reach a result.
// the job queue (4 words) and result queue (4 words) let either side stall.
module int8_pool2d_avg_max
  import ipool_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] pixel_i,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] pooled_o,
  output logic [8:0] out_row_o,
  output logic [8:0] out_col_o,
  output logic       plane_done_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    cfg_wr, restart;
  job_t    job_in, job_out;
  logic    job_push, job_full, job_pop, job_empty;
  result_t res_in, res_out;
  logic    res_push, res_full;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // register writes; geometry writes restart the plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_mode    <= 1'b0;
      cfg_q.win_side     <= 2'd2;
      cfg_q.step_size    <= 2'd2;
      cfg_q.pad_amount   <= 1'b0;
      cfg_q.plane_height <= 9'd256;
      cfg_q.plane_width  <= 9'd256;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_POOL_MODE:    cfg_q.pool_mode    <= cfg_data_i[0];
        REG_WIN_SIDE:     cfg_q.win_side     <= cfg_data_i[1:0];
        REG_STEP_SIZE:    cfg_q.step_size    <= cfg_data_i[1:0];
        REG_PAD_AMOUNT:   cfg_q.pad_amount   <= cfg_data_i[0];
        REG_PLANE_HEIGHT: cfg_q.plane_height <= cfg_data_i;
        REG_PLANE_WIDTH:  cfg_q.plane_width  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign restart = cfg_wr && (cfg_index_i == REG_WIN_SIDE
                           || cfg_index_i == REG_STEP_SIZE
                           || cfg_index_i == REG_PAD_AMOUNT
                           || cfg_index_i == REG_PLANE_HEIGHT
                           || cfg_index_i == REG_PLANE_WIDTH);

  // front end: intake and window finder
  ipool_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .restart_i  (restart),
    .push_i     (push),
    .pixel_i    (pixel_i),
    .full_o     (full),
    .job_o      (job_in),
    .job_push_o (job_push),
    .job_full_i (job_full)
  );

  // job queue between front and back
  ipool_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .T     (job_t)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // back end: reduction and divider
  ipool_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pool_mode_i (cfg_q.pool_mode),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue toward the consumer
  ipool_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .T     (result_t)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign pooled_o     = res_out.pooled;
  assign out_row_o    = res_out.out_row;
  assign out_col_o    = res_out.out_col;
  assign plane_done_o = res_out.plane_done;

endmodule

[sim/int8_pool2d_avg_max_tb.sv]
// int8_pool2d_avg_max_tb: self-checking bench for the int8 2-D pooling block
// depends on ipool_pkg and int8_pool2d_avg_max; predicts each pooled word in
// the bench and checks every result word against that queue of expected words
module int8_pool2d_avg_max_tb;
  import ipool_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] pixel_i = '0;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] pooled_o;
  logic [8:0] out_row_o;
  logic [8:0] out_col_o;
  logic       plane_done_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;

  int8_pool2d_avg_max u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .pixel_i     (pixel_i),
    .pop         (pop),
    .empty       (empty),
    .pooled_o    (pooled_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .plane_done_o(plane_done_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic       pm_mode;
  logic [1:0] pm_win;
  logic [1:0] pm_step;
  logic       pm_pad;
  logic [8:0] pm_height;
  logic [8:0] pm_width;
  int         line_buf [2][256];
  int         col_hist [2][3];
  int         cur_row, cur_col;

  result_t    pooled_q [$];
  int         n_errors = 0;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         hold_cycles = 0;

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // apply one register write to the predictor
  function automatic void pool_reg_write(cfg_reg_e idx, logic [8:0] val);
    case (idx)
      REG_POOL_MODE: begin
        pm_mode = val[0];
        return;
      end
      REG_WIN_SIDE:     pm_win = val[1:0];
      REG_STEP_SIZE:    pm_step = val[1:0];
      REG_PAD_AMOUNT:   pm_pad = val[0];
      REG_PLANE_HEIGHT: pm_height = val;
      REG_PLANE_WIDTH:  pm_width = val;
      default: return;
    endcase
    cur_row = 0;
    cur_col = 0;
  endfunction

  // predict the pooled words caused by one pixel
  function automatic void pool_predict(logic signed [7:0] pix);
    int k, s, p, h, w, oh_n, ow_n, r, c, t, oh0, ow0, rl, cl;
    int sum, cnt, mx, ir, ic, d, j, v, val;
    int cur [3];
    result_t res;
    k = clip(pm_win, 2, 3);
    s = clip(pm_step, 1, 2);
    p = pm_pad;
    h = clip(pm_height, 3, 256);
    w = clip(pm_width, 3, 256);
    oh_n = (h + 2 * p - k) / s + 1;
    ow_n = (w + 2 * p - k) / s + 1;
    r = clip(cur_row, 0, h - 1);
    c = clip(cur_col, 0, w - 1);
    cur[0] = int'(pix);
    cur[1] = line_buf[(r + 1) % 2][c];
    cur[2] = line_buf[r % 2][c];
    line_buf[r % 2][c] = int'(pix);
    t = r + p + 1 - k;
    oh0 = t <= 0 ? 0 : (t + s - 1) / s;
    t = c + p + 1 - k;
    ow0 = t <= 0 ? 0 : (t + s - 1) / s;
    for (int oh = oh0; oh < oh_n; oh++) begin
      rl = oh * s - p + k - 1;
      if ((rl < h - 1 ? rl : h - 1) != r) break;
      for (int ow = ow0; ow < ow_n; ow++) begin
        cl = ow * s - p + k - 1;
        if ((cl < w - 1 ? cl : w - 1) != c) break;
        sum = 0;
        cnt = 0;
        mx = -128;
        for (int kh = 0; kh < k; kh++) begin
          for (int kw = 0; kw < k; kw++) begin
            ir = oh * s - p + kh;
            ic = ow * s - p + kw;
            if (ir < 0 || ir >= h || ic < 0 || ic >= w) continue;
            d = r - ir;
            j = c - ic;
            if (d < 0 || d > 2 || j < 0 || j > 2) continue;
            v = (j == 0) ? cur[d] : col_hist[j - 1][d];
            if (cnt == 0 || v > mx) mx = v;
            sum += v;
            cnt++;
          end
        end
        if (cnt == 0) val = 0;
        else if (pm_mode) val = mx;
        else val = sum / cnt;
        res.pooled = val[7:0];
        res.out_row = oh[8:0];
        res.out_col = ow[8:0];
        res.plane_done = (oh == oh_n - 1) && (ow == ow_n - 1);
        pooled_q.push_back(res);
      end
    end
    for (int i = 0; i < 3; i++) begin
      col_hist[1][i] = col_hist[0][i];
      col_hist[0][i] = cur[i];
    end
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
  endfunction

  // send one pixel word, with random sender gaps
  task automatic send_pixel(logic [7:0] pix);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    pixel_i <= pix;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pool_predict(pix);
  endtask

  // wait for every expected word, then let the back end drain
  task automatic drain();
    push <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [8:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pool_reg_write(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(int mode, int k, int s, int p, int h, int w);
    drain();
    write_reg(REG_POOL_MODE, 9'(mode));
    write_reg(REG_WIN_SIDE, 9'(k));
    write_reg(REG_STEP_SIZE, 9'(s));
    write_reg(REG_PAD_AMOUNT, 9'(p));
    write_reg(REG_PLANE_HEIGHT, 9'(h));
    write_reg(REG_PLANE_WIDTH, 9'(w));
  endtask

  // receiver: pops with random stalls and long hold-offs, checks each word
  always @(posedge clk_i) begin
    result_t exp_w;
    if (pop && !empty) begin
      if (pooled_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected word row %0d col %0d", out_row_o, out_col_o);
      end else begin
        exp_w = pooled_q.pop_front();
        if (pooled_o !== exp_w.pooled || out_row_o !== exp_w.out_row ||
            out_col_o !== exp_w.out_col || plane_done_o !== exp_w.plane_done) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch exp %0d r%0d c%0d d%0b got %0d r%0d c%0d d%0b",
                     $signed(exp_w.pooled), exp_w.out_row, exp_w.out_col,
                     exp_w.plane_done, $signed(pooled_o), out_row_o, out_col_o,
                     plane_done_o);
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  // directed: extremes, both modes, padding, -128 inside averages, odd sizes
  task automatic test_directed();
    set_geometry(0, 2, 2, 0, 4, 4);
    for (int i = 0; i < 16; i++) send_pixel(i % 2 ? 8'h80 : 8'h7f);
    set_geometry(1, 3, 1, 1, 3, 3);
    for (int i = 0; i < 9; i++) send_pixel(8'h80);
    set_geometry(0, 3, 2, 1, 3, 3);
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'h01 : 8'h80);
  endtask

  // random planes across settings and idling phases
  task automatic test_random(int planes, int s_idle, int r_idle);
    int h, w;
    drain();
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int pl = 0; pl < planes; pl++) begin
      h = $urandom_range(3, 5);
      w = $urandom_range(3, 6);
      set_geometry($urandom_range(1), $urandom_range(2, 3), $urandom_range(1, 2),
                   $urandom_range(1), h, w);
      if ($urandom_range(3) == 0) write_reg(REG_POOL_MODE, 9'($urandom_range(1)));
      for (int i = 0; i < h * w; i++) send_pixel(8'($urandom));
    end
  endtask

  // out-of-range settings and an unknown index
  task automatic test_clamps();
    set_geometry(1, 0, 0, 0, 511, 0);
    for (int i = 0; i < 30; i++) send_pixel(8'($urandom));
    set_geometry(0, 3, 3, 1, 2, 5);
    write_reg(cfg_reg_e'(3'd7), 9'h1ff);
    for (int i = 0; i < 15; i++) send_pixel(8'($urandom));
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_backpressure();
    set_geometry(1, 2, 1, 1, 4, 4);
    send_idle = 0;
    hold_cycles = 200;
    for (int i = 0; i < 16; i++) send_pixel(8'($urandom));
    drain();
    for (int i = 0; i < 16; i++) send_pixel(8'($urandom));
  endtask

  initial begin
    pool_reg_write(REG_POOL_MODE, 9'd0);
    pm_win = 2'd2;
    pm_step = 2'd2;
    pm_pad = 1'b0;
    pm_height = 9'd256;
    pm_width = 9'd256;
    cur_row = 0;
    cur_col = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(3, 0, 0);
    test_random(3, 79, 0);
    test_random(3, 0, 79);
    test_random(3, 30, 30);
    send_idle = 0;
    recv_idle = 0;
    test_clamps();
    test_backpressure();
    drain();
    if (n_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
